// ===== rtl/mcbf_pkg.sv =====
package mcbf_pkg;

  localparam int NUM_CHANNELS  = 16;
  localparam int CHANNEL_DEPTH = 16;

  localparam int REQ_W  = 2;
  localparam int PIPE_W = 4;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
  localparam int ADDR_W = $clog2(NUM_CHANNELS * CHANNEL_DEPTH);
  // wide enough to hold pipe_id, any channel number and NUM_CHANNELS itself
  localparam int CHX_W  = ((CH_W > PIPE_W) ? CH_W : PIPE_W) + 1;

  localparam logic [BYTE_W-1:0] EMPTY_MARK = 8'h45;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 2'd0,
    REQ_FLUSH  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_WRITE  = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_FREE     = 2'd1,
    ST_FULL_OR_OFF = 2'd2,
    ST_EMPTY       = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/mcbf_if.sv =====
interface mcbf_in_if;
  import mcbf_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PIPE_W-1:0] pipe_id;
  logic [BYTE_W-1:0] write_data;

  modport source (output valid, output req_type, output pipe_id, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input pipe_id, input write_data,
                  output ready);
endinterface

interface mcbf_out_if;
  import mcbf_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] read_byte;
  logic [PIPE_W-1:0] new_pipe_id;

  modport source (output valid, output status, output read_byte, output new_pipe_id,
                  input ready);
  modport sink   (input valid, input status, input read_byte, input new_pipe_id,
                  output ready);
endinterface

// ===== rtl/mcbf_ctrl.sv =====
module mcbf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mcbf_pkg::stat_t stat,
  output mcbf_pkg::cmd_t  cmd
);
  import mcbf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ready_r && in_valid) begin
            state_r    <= S_EXEC;
            in_ready_r <= 1'b0;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          // wait for the result register to free up
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready    = in_ready_r;
  assign cmd.capture = in_ready_r && in_valid;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.load    = (state_r == S_DONE) && stat.out_free;

  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.exec)
    else $error("accepted transaction not executed next cycle");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == S_IDLE))
    else $error("ready while a transaction is in flight");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_ready_r)
    else $error("not ready after result load");

endmodule

// ===== rtl/mcbf_datapath.sv =====
module mcbf_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcbf_pkg::cmd_t              cmd,
  output mcbf_pkg::stat_t             stat,
  input  logic [mcbf_pkg::REQ_W-1:0]  in_req_type,
  input  logic [mcbf_pkg::PIPE_W-1:0] in_pipe_id,
  input  logic [mcbf_pkg::BYTE_W-1:0] in_write_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [mcbf_pkg::STAT_W-1:0] out_status,
  output logic [mcbf_pkg::BYTE_W-1:0] out_read_byte,
  output logic [mcbf_pkg::PIPE_W-1:0] out_new_pipe_id
);
  import mcbf_pkg::*;

  typedef enum logic [1:0] {
    RSEL_ZERO,
    RSEL_MARK,
    RSEL_MEM
  } rsel_t;

  // captured request
  req_t              req_r;
  logic [PIPE_W-1:0] ch_r;
  logic [BYTE_W-1:0] data_r;

  // per-channel state
  logic [SLOT_W-1:0]       head_r [NUM_CHANNELS];
  logic [SLOT_W-1:0]       tail_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] in_use_r;
  logic [NUM_CHANNELS-1:0] full_r;

  logic [BYTE_W-1:0] mem [NUM_CHANNELS * CHANNEL_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // execute-stage result
  status_t           res_status_r;
  logic [PIPE_W-1:0] res_newid_r;
  rsel_t             res_sel_r;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [PIPE_W-1:0] out_newid_r;

  logic [CHX_W-1:0]  ch_ext;
  logic              ch_valid;
  logic [CH_W-1:0]   ch_idx;
  logic [SLOT_W-1:0] head_cur;
  logic [SLOT_W-1:0] tail_cur;
  logic [SLOT_W-1:0] head_inc;
  logic [SLOT_W-1:0] tail_inc;
  logic              ch_empty;
  logic              free_any;
  logic [CH_W-1:0]   free_idx;
  logic              open_en;
  logic [CH_W-1:0]   open_idx;
  logic              rd_ok;
  logic              wr_ok;
  status_t           status_c;
  logic [PIPE_W-1:0] newid_c;
  rsel_t             sel_c;
  logic [ADDR_W-1:0] mem_addr;

  assign ch_ext   = CHX_W'(ch_r);
  assign ch_valid = ch_ext < CHX_W'(NUM_CHANNELS);
  assign ch_idx   = ch_ext[CH_W-1:0];
  assign head_cur = head_r[ch_idx];
  assign tail_cur = tail_r[ch_idx];
  assign head_inc = (head_cur == SLOT_W'(CHANNEL_DEPTH - 1)) ? '0 : head_cur + 1'b1;
  assign tail_inc = (tail_cur == SLOT_W'(CHANNEL_DEPTH - 1)) ? '0 : tail_cur + 1'b1;
  assign ch_empty = (head_cur == tail_cur) && !full_r[ch_idx];

  // lowest free channel
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_any = 1'b1;
        free_idx = CH_W'(i);
      end
    end
  end

  always_comb begin
    open_en  = 1'b0;
    open_idx = ch_idx;
    rd_ok    = 1'b0;
    wr_ok    = 1'b0;
    status_c = ST_OK;
    newid_c  = '0;
    sel_c    = RSEL_ZERO;
    case (req_r)
      REQ_CREATE: begin
        if (free_any) begin
          open_en  = 1'b1;
          open_idx = free_idx;
          newid_c  = PIPE_W'(free_idx);
        end else begin
          status_c = ST_NO_FREE;
        end
      end
      REQ_FLUSH: begin
        if (ch_valid) begin
          open_en = 1'b1;
        end else begin
          status_c = ST_FULL_OR_OFF;
        end
      end
      REQ_READ: begin
        if (!ch_valid || ch_empty) begin
          status_c = ST_EMPTY;
          sel_c    = RSEL_MARK;
        end else begin
          rd_ok = 1'b1;
          sel_c = RSEL_MEM;
        end
      end
      REQ_WRITE: begin
        if (!ch_valid || !in_use_r[ch_idx] || full_r[ch_idx]) begin
          status_c = ST_FULL_OR_OFF;
        end else begin
          wr_ok = 1'b1;
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  assign mem_addr = ADDR_W'(ch_idx) * ADDR_W'(CHANNEL_DEPTH)
                  + ADDR_W'(req_r == REQ_WRITE ? tail_cur : head_cur);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_t'(in_req_type);
      ch_r   <= in_pipe_id;
      data_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      in_use_r <= '0;
      full_r   <= '0;
    end else if (cmd.exec) begin
      if (open_en) begin
        in_use_r[open_idx] <= 1'b1;
        head_r[open_idx]   <= '0;
        tail_r[open_idx]   <= '0;
        full_r[open_idx]   <= 1'b0;
      end
      if (rd_ok) begin
        head_r[ch_idx] <= head_inc;
        full_r[ch_idx] <= 1'b0;
      end
      if (wr_ok) begin
        tail_r[ch_idx] <= tail_inc;
        if (tail_inc == head_cur) begin
          full_r[ch_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_ok) begin
      mem[mem_addr] <= data_r;
    end
    if (cmd.exec && rd_ok) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= status_c;
      res_newid_r  <= newid_c;
      res_sel_r    <= sel_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= res_status_r;
      out_newid_r  <= res_newid_r;
      case (res_sel_r)
        RSEL_MARK: out_byte_r <= EMPTY_MARK;
        RSEL_MEM:  out_byte_r <= rd_data_r;
        default:   out_byte_r <= '0;
      endcase
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_byte   = out_byte_r;
  assign out_new_pipe_id = out_newid_r;

  a_full_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_valid && full_r[ch_idx]) |-> (head_cur == tail_cur))
    else $error("full channel with head and tail apart");

  a_write_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && wr_ok) |=>
      (full_r[$past(ch_idx)] || head_r[$past(ch_idx)] != tail_r[$past(ch_idx)]))
    else $error("channel empty after a successful write");

  a_read_clears_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && rd_ok) |=> !full_r[$past(ch_idx)])
    else $error("channel still full after a successful read");

  a_create_claims: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && req_r == REQ_CREATE && free_any) |=> in_use_r[$past(free_idx)])
    else $error("create did not claim the free channel");

endmodule

// ===== rtl/multi_channel_byte_fifo_pool.sv =====
// a captured transaction is executed with store access in the execute step and its result
// is moved into the output register by the load step once that register is free
// a new transaction is taken only after the last result is loaded, so a held result
// stalls the input; the controller's capture, execute and load steps set the pace
// reset: synchronous, active low; clears channel indices, enable and full flags
// the byte store is not cleared and the block is ready in the cycle after reset ends
module multi_channel_byte_fifo_pool (
  input logic        clk,
  input logic        rst_n,
  mcbf_in_if.sink    in_ch,
  mcbf_out_if.source out_ch
);
  import mcbf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ready;

  mcbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcbf_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_ch.req_type),
    .in_pipe_id      (in_ch.pipe_id),
    .in_write_data   (in_ch.write_data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_read_byte   (out_ch.read_byte),
    .out_new_pipe_id (out_ch.new_pipe_id)
  );

  assign in_ch.ready = ready;

endmodule

// ===== tb/tb_multi_channel_byte_fifo_pool.sv =====
`timescale 1ns / 100ps

module tb_multi_channel_byte_fifo_pool;
  import mcbf_pkg::*;

  localparam int RAND_ITEMS   = 1150;
  localparam int QUIET_AFTER  = 1000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 120;
  localparam int WATCHDOG     = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] read_byte;
    logic [PIPE_W-1:0] new_pipe_id;
  } pool_resp_t;

  typedef struct {
    req_t              op;
    logic [PIPE_W-1:0] ch;
    logic [BYTE_W-1:0] data;
    bit                typed;
    pool_resp_t        want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mcbf_in_if  in_bus ();
  mcbf_out_if out_bus ();

  multi_channel_byte_fifo_pool dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // shadow of the channel pool
  logic [SLOT_W-1:0] chan_head  [NUM_CHANNELS];
  logic [SLOT_W-1:0] chan_tail  [NUM_CHANNELS];
  bit                chan_on    [NUM_CHANNELS];
  bit                chan_full  [NUM_CHANNELS];
  logic [BYTE_W-1:0] chan_bytes [NUM_CHANNELS][CHANNEL_DEPTH];

  pool_resp_t pending_responses [$];
  stim_row_t  directed_rows [$];

  int mismatches = 0;
  int items_accepted;
  int idle_cycles = 0;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] idx);
    return (int'(idx) == CHANNEL_DEPTH - 1) ? '0 : idx + 1'b1;
  endfunction

  function automatic void open_channel(int ch);
    chan_on[ch]   = 1'b1;
    chan_head[ch] = '0;
    chan_tail[ch] = '0;
    chan_full[ch] = 1'b0;
  endfunction

  function automatic pool_resp_t serve_request(req_t op, logic [PIPE_W-1:0] pipe,
                                               logic [BYTE_W-1:0] data);
    pool_resp_t r;
    int         ch;
    bit         in_range;
    ch       = int'(pipe);
    in_range = ch < NUM_CHANNELS;
    r        = '{status: ST_OK, read_byte: '0, new_pipe_id: '0};
    case (op)
      REQ_CREATE: begin
        r.status = ST_NO_FREE;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (!chan_on[i]) begin
            open_channel(i);
            r.status      = ST_OK;
            r.new_pipe_id = PIPE_W'(i);
            break;
          end
        end
      end
      REQ_FLUSH: begin
        if (in_range) open_channel(ch);
        else r.status = ST_FULL_OR_OFF;
      end
      REQ_READ: begin
        if (!in_range || (chan_head[ch] == chan_tail[ch] && !chan_full[ch])) begin
          r.status    = ST_EMPTY;
          r.read_byte = EMPTY_MARK;
        end else begin
          r.read_byte   = chan_bytes[ch][chan_head[ch]];
          chan_head[ch] = next_slot(chan_head[ch]);
          chan_full[ch] = 1'b0;
        end
      end
      default: begin
        if (!in_range || !chan_on[ch] || chan_full[ch]) begin
          r.status = ST_FULL_OR_OFF;
        end else begin
          chan_bytes[ch][chan_tail[ch]] = data;
          chan_tail[ch] = next_slot(chan_tail[ch]);
          if (chan_tail[ch] == chan_head[ch]) chan_full[ch] = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // mostly lands on an enabled channel when asked to
  function automatic logic [PIPE_W-1:0] pick_channel(bit want_on);
    int ch;
    ch = $urandom_range(0, NUM_CHANNELS - 1);
    for (int t = 0; t < 4 && want_on && !chan_on[ch]; t++)
      ch = $urandom_range(0, NUM_CHANNELS - 1);
    return PIPE_W'(ch);
  endfunction

  task automatic issue_request(input req_t op, input logic [PIPE_W-1:0] ch,
                               input logic [BYTE_W-1:0] data, input bit typed,
                               input pool_resp_t want);
    pool_resp_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid      <= 1'b1;
    in_bus.req_type   <= op;
    in_bus.pipe_id    <= ch;
    in_bus.write_data <= data;
    do @(posedge clk); while (!in_bus.ready);
    predicted = serve_request(op, ch, data);
    pending_responses.push_back(typed ? want : predicted);
    items_accepted++;
  endtask

  function automatic stim_row_t mk_row(req_t op, logic [PIPE_W-1:0] ch,
                                       logic [BYTE_W-1:0] data, bit typed,
                                       status_t st, logic [BYTE_W-1:0] rb,
                                       logic [PIPE_W-1:0] nid);
    stim_row_t row;
    row.op    = op;
    row.ch    = ch;
    row.data  = data;
    row.typed = typed;
    row.want  = '{status: st, read_byte: rb, new_pipe_id: nid};
    return row;
  endfunction

  // result side: random short stalls plus one long hold-off to back up the pool
  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pool_resp_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected response: status=%0d read_byte=%02h new_pipe_id=%0d",
                   out_bus.status, out_bus.read_byte, out_bus.new_pipe_id);
      end else begin
        want = pending_responses.pop_front();
        if (out_bus.status !== want.status || out_bus.read_byte !== want.read_byte ||
            out_bus.new_pipe_id !== want.new_pipe_id) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected status=%0d read_byte=%02h new_pipe_id=%0d,",
                     want.status, want.read_byte, want.new_pipe_id,
                     " got status=%0d read_byte=%02h new_pipe_id=%0d",
                     out_bus.status, out_bus.read_byte, out_bus.new_pipe_id);
        end
      end
    end
  end

  // stuck detector: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("tb_multi_channel_byte_fifo_pool NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : request_source
    pool_resp_t none;
    stim_row_t  row;
    int         sent;
    int         kind;
    int         len;
    logic [PIPE_W-1:0] ch;
    none           = '{status: ST_OK, read_byte: '0, new_pipe_id: '0};
    items_accepted = 0;
    quiet          = 1'b0;
    sent           = 0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_head[c] = '0;
      chan_tail[c] = '0;
      chan_on[c]   = 1'b0;
      chan_full[c] = 1'b0;
    end
    in_bus.valid      = 1'b0;
    in_bus.req_type   = REQ_CREATE;
    in_bus.pipe_id    = '0;
    in_bus.write_data = '0;
    rst_n             = 1'b0;

    // expected result given only where it is obvious
    directed_rows.push_back(mk_row(REQ_READ,   4'd0,  8'h00, 1, ST_EMPTY, EMPTY_MARK, 4'd0));
    directed_rows.push_back(mk_row(REQ_WRITE,  4'd0,  8'hFF, 1, ST_FULL_OR_OFF, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_READ,   4'd15, 8'h00, 1, ST_EMPTY, EMPTY_MARK, 4'd0));
    directed_rows.push_back(mk_row(REQ_FLUSH,  4'd15, 8'h00, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_CREATE, 4'd9,  8'h00, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_CREATE, 4'd0,  8'hFF, 1, ST_OK, 8'h00, 4'd1));
    directed_rows.push_back(mk_row(REQ_WRITE,  4'd0,  8'h00, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_WRITE,  4'd0,  8'hFF, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_READ,   4'd0,  8'h00, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_READ,   4'd0,  8'h00, 1, ST_OK, 8'hFF, 4'd0));
    directed_rows.push_back(mk_row(REQ_READ,   4'd0,  8'h00, 1, ST_EMPTY, EMPTY_MARK, 4'd0));
    directed_rows.push_back(mk_row(REQ_WRITE,  4'd15, 8'hA5, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_WRITE,  4'd15, 8'h5A, 0, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_READ,   4'd15, 8'h00, 0, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_FLUSH,  4'd15, 8'h00, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_READ,   4'd15, 8'h00, 1, ST_EMPTY, EMPTY_MARK, 4'd0));
    directed_rows.push_back(mk_row(REQ_WRITE,  4'd1,  8'h3C, 0, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_FLUSH,  4'd1,  8'h00, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_READ,   4'd1,  8'h00, 1, ST_EMPTY, EMPTY_MARK, 4'd0));
    directed_rows.push_back(mk_row(REQ_CREATE, 4'd15, 8'h00, 1, ST_OK, 8'h00, 4'd2));
    directed_rows.push_back(mk_row(REQ_WRITE,  4'd7,  8'h81, 1, ST_FULL_OR_OFF, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_FLUSH,  4'd7,  8'h00, 1, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_WRITE,  4'd7,  8'h7E, 0, ST_OK, 8'h00, 4'd0));
    directed_rows.push_back(mk_row(REQ_READ,   4'd7,  8'h00, 0, ST_OK, 8'h00, 4'd0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue_request(row.op, row.ch, row.data, row.typed, row.want);
    end

    // mostly well-formed bursts on one channel, some plain noise
    while (sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) len = $urandom_range(1, 4);
      else if (kind < 18) len = 1;
      else if (kind < 70) len = $urandom_range(1, 20);
      else if (kind < 85) len = $urandom_range(4, 24);
      else len = $urandom_range(1, 6);
      ch = pick_channel(kind >= 18 && kind < 85);
      for (int k = 0; k < len && sent < RAND_ITEMS; k++) begin
        quiet = sent >= QUIET_AFTER;
        if (kind < 10)
          issue_request(REQ_CREATE, PIPE_W'($urandom), BYTE_W'($urandom), 0, none);
        else if (kind < 18)
          issue_request(REQ_FLUSH, ch, BYTE_W'($urandom), 0, none);
        else if (kind < 45)
          issue_request(REQ_WRITE, ch, BYTE_W'($urandom), 0, none);
        else if (kind < 70)
          issue_request(REQ_READ, ch, BYTE_W'($urandom), 0, none);
        else if (kind < 85)
          issue_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, ch,
                        BYTE_W'($urandom), 0, none);
        else
          issue_request(req_t'($urandom_range(0, 3)), PIPE_W'($urandom),
                        BYTE_W'($urandom), 0, none);
        sent++;
      end
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_multi_channel_byte_fifo_pool OK");
    end else begin
      $display("tb_multi_channel_byte_fifo_pool NOT OK");
    end
    $finish;
  end

endmodule
